// ----- rtl/core/rbfe_pkg.sv -----
// Shared types and constants for the brace frame extractor core.
// No dependencies; imported by every module of the core.
`default_nettype none

package rbfe_pkg;

    localparam int BYTE_W = 8;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_RX    = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_OPEN  = 1'b0;
    localparam logic CFG_CLOSE = 1'b1;

    localparam logic [BYTE_W-1:0] OPEN_RESET  = 8'd123;
    localparam logic [BYTE_W-1:0] CLOSE_RESET = 8'd125;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_SCAN,
        ST_EMIT,
        ST_EMPTY
    } t_state;

    // One result handed from the sequencer to the output register.
    typedef struct packed {
        logic              load;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              empty;
    } t_out_load;

endpackage

`default_nettype wire

// ----- rtl/core/rbfe_store.sv -----
// Byte store of the ring buffer: one write port, one read port with a
// registered read. Depends on rbfe_pkg.
`default_nettype none

module rbfe_store
    import rbfe_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [BYTE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/rbfe_out.sv -----
// Output register of the frame extractor: holds one result until the
// receiver takes it. Depends on rbfe_pkg.
`default_nettype none

module rbfe_out
    import rbfe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_out_load         i_load,
    output logic                   o_free,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [BYTE_W-1:0] o_out_byte,
    output logic                   o_out_last,
    output logic                   o_out_empty_res
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_empty;

    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load.load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_byte  <= i_load.data;
            r_last  <= i_load.last;
            r_empty <= i_load.empty;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_out_byte      = r_byte;
    assign o_out_last      = r_last;
    assign o_out_empty_res = r_empty;

endmodule

`default_nettype wire

// ----- rtl/core/rbfe_ctrl.sv -----
// Sequencer of the frame extractor: pointers, remembered frame start,
// delimiter registers and the read walk over the byte store.
// Depends on rbfe_pkg; drives rbfe_store and rbfe_out.
`default_nettype none

module rbfe_ctrl
    import rbfe_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_kind,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [BYTE_W-1:0] i_cfg_data,
    output logic                   o_we,
    output logic      [AW-1:0]     o_waddr,
    output logic      [BYTE_W-1:0] o_wdata,
    output logic      [AW-1:0]     o_raddr,
    input  wire logic [BYTE_W-1:0] i_rdata,
    input  wire logic              i_out_free,
    output t_out_load              o_load
);

    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

    t_state            r_state, n_state;
    logic [AW-1:0]     r_wp, n_wp;
    logic [AW-1:0]     r_rp, n_rp;
    logic [AW-1:0]     r_sp, n_sp;
    logic [AW-1:0]     r_stop, n_stop;
    logic              r_sf, n_sf;
    logic [BYTE_W-1:0] r_open;
    logic [BYTE_W-1:0] r_close;

    logic          accept;
    logic [AW-1:0] wp_nx, rp_nx, sp_nx;
    logic          open_hit, close_hit;

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
        return (p == LAST_POS) ? '0 : p + AW'(1);
    endfunction

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign wp_nx      = next_pos(r_wp);
    assign rp_nx      = next_pos(r_rp);
    assign sp_nx      = next_pos(r_sp);
    assign open_hit   = (i_rdata == r_open);
    assign close_hit  = (i_rdata == r_close);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_kind == KIND_DRAIN) begin
                        n_state = (r_rp == r_wp) ? ST_EMPTY : ST_EMIT;
                    end else if (i_kind == KIND_READ && !r_sf) begin
                        n_state = (r_rp == r_wp) ? ST_EMPTY : ST_SKIP;
                    end else if (i_kind == KIND_READ) begin
                        n_state = (r_sp == r_wp) ? ST_EMPTY : ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SKIP: begin
                if (open_hit) begin
                    n_state = ST_SCAN;
                end else if (rp_nx == r_wp) begin
                    n_state = ST_EMPTY;
                end
            end
            ST_SCAN: begin
                if (close_hit) begin
                    n_state = (r_rp == sp_nx) ? ST_EMPTY : ST_EMIT;
                end else if (sp_nx == r_wp) begin
                    n_state = ST_EMPTY;
                end
            end
            ST_EMIT: begin
                if (i_out_free && rp_nx == r_stop) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // The read address always points at the byte needed in the next cycle,
    // so the walk advances one entry per cycle unless an emit is stalled.
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_sp    = r_sp;
        n_sf    = r_sf;
        n_stop  = r_stop;
        o_we    = 1'b0;
        o_waddr = r_wp;
        o_wdata = i_rx_byte;
        o_raddr = r_rp;
        o_load  = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_raddr = (i_kind == KIND_READ && r_sf) ? r_sp : r_rp;
                if (accept && i_kind == KIND_RX) begin
                    o_we = 1'b1;
                    n_wp = wp_nx;
                    if (wp_nx == r_rp) begin
                        n_rp = rp_nx;
                    end
                    if (wp_nx == r_sp) begin
                        n_sp = sp_nx;
                    end
                end else if (accept && i_kind == KIND_DRAIN) begin
                    n_sf   = 1'b0;
                    n_stop = r_wp;
                end
            end
            ST_SKIP: begin
                if (open_hit) begin
                    n_sf    = 1'b1;
                    n_sp    = r_rp;
                    o_raddr = r_rp;
                end else begin
                    n_rp    = rp_nx;
                    o_raddr = rp_nx;
                end
            end
            ST_SCAN: begin
                n_sp = sp_nx;
                if (close_hit) begin
                    n_sf    = 1'b0;
                    n_stop  = sp_nx;
                    o_raddr = r_rp;
                end else begin
                    o_raddr = sp_nx;
                end
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    o_load.load = 1'b1;
                    o_load.data = i_rdata;
                    o_load.last = (rp_nx == r_stop);
                    n_rp        = rp_nx;
                    o_raddr     = rp_nx;
                end
            end
            ST_EMPTY: begin
                if (i_out_free) begin
                    o_load.load  = 1'b1;
                    o_load.last  = 1'b1;
                    o_load.empty = 1'b1;
                end
            end
            default: begin
                o_load = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_sp    <= '0;
            r_sf    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_sp    <= n_sp;
            r_sf    <= n_sf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stop <= n_stop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= OPEN_RESET;
            r_close <= CLOSE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OPEN:  r_open  <= i_cfg_data;
                CFG_CLOSE: r_close <= i_cfg_data;
                default:   r_open  <= r_open;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ring_buffer_brace_frame_extractor_core.sv -----
// Receive ring buffer that hands out frames delimited by an open and a close
// byte. Input channel (i_in_valid / o_in_stall) carries a kind and a byte:
// receive stores the byte, read returns the next complete frame, drain
// returns every unread byte. Output channel (o_out_valid / i_out_stall)
// carries one byte per transaction; the final byte of a read or drain has
// o_out_last set. A read or drain with nothing to give returns a single
// transaction with o_out_empty_res and o_out_last set and a zero byte.
// A receive is written straight into the store and the next item is taken at once.
// A read walks the byte store through its single read port: it accepts the
// item, skips the bytes before the open delimiter and then takes the open byte
// when no start is remembered, scans the bytes up to and including the close
// delimiter, then emits each byte of the frame, or gives an empty answer. A
// drain accepts the item and emits each unread byte, or gives an empty answer
// when nothing is unread.
// The input stalls while a read or drain is in progress; a stalled receiver
// freezes the emit walk but the last result sits in an output register, so
// the next item is taken while it waits. Synchronous reset empties the
// buffer, forgets any frame start and restores the default delimiters; the
// byte store itself is not cleared.
// Depends on rbfe_pkg, rbfe_ctrl, rbfe_store and rbfe_out.
`default_nettype none

module ring_buffer_brace_frame_extractor_core
    import rbfe_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_kind,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [BYTE_W-1:0] o_out_byte,
    output logic                   o_out_last,
    output logic                   o_out_empty_res,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [BYTE_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(DEPTH);

    logic              we;
    logic [AW-1:0]     waddr;
    logic [BYTE_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [BYTE_W-1:0] rdata;
    logic              out_free;
    t_out_load         out_load;

    rbfe_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .i_out_free  (out_free),
        .o_load      (out_load)
    );

    rbfe_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    rbfe_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (out_load),
        .o_free          (out_free),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_out_last      (o_out_last),
        .o_out_empty_res (o_out_empty_res)
    );

endmodule

`default_nettype wire

// ----- rtl/core/rbfe_checker.sv -----
// Port-level checks for the frame extractor core, bound to the top level.
// Depends on rbfe_pkg.
`default_nettype none

module rbfe_checker
    import rbfe_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic [1:0]        i_kind,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [BYTE_W-1:0] o_out_byte,
    input wire logic              o_out_last,
    input wire logic              o_out_empty_res
);

    // No result is pending right after reset.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // An empty answer is always the single, final transaction with a zero byte.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_empty_res |-> o_out_last && o_out_byte == '0)
        else $error("empty result not final or not zero");

    // A read always produces at least one result, so the input stays busy.
    a_read_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_kind == KIND_READ |=> o_in_stall)
        else $error("read accepted without going busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_out_last))
        else $error("stalled result changed");

endmodule

bind ring_buffer_brace_frame_extractor_core rbfe_checker u_rbfe_checker (.*);

`default_nettype wire
